[rtl/core/msb_first_bit_field_packer_macros.svh]
// ----------------------------------------------------------------------------
// msb_first_bit_field_packer_macros.svh
// Assertion helpers for the bit-field packer checkers.
// The enclosing scope must provide clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef MSB_FIRST_BIT_FIELD_PACKER_MACROS_SVH
`define MSB_FIRST_BIT_FIELD_PACKER_MACROS_SVH

// Same-cycle implication, checked out of reset
`define MSBFP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define MSBFP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/msbfp_pkg.sv]
// ----------------------------------------------------------------------------
// msbfp_pkg
// Shared types and constants for the MSB-first bit-field packer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package msbfp_pkg;

    localparam int MAX_BYTES      = 65536;
    localparam int MAX_FIELD_BITS = 32;
    localparam int CAP_W          = 17;   // capacity / stream length width
    localparam int POS_W          = 20;   // bit position width
    localparam int WIN_W          = 40;   // five-byte assembly window
    localparam int IDX_W          = 16;
    localparam int CNT_W          = 3;    // bytes remaining in a window

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);
    localparam logic [CAP_W-1:0] CAP_MAX   = CAP_W'(MAX_BYTES);

    // Input beat
    typedef struct packed {
        logic [5:0]  field_width;
        logic [31:0] field_value;
    } field_t;

    // Output beat
    typedef struct packed {
        logic             write_valid;
        logic [IDX_W-1:0] byte_index;
        logic [7:0]       byte_value;
        logic             accepted;
        logic [CAP_W-1:0] stream_bytes;
        logic             last;
    } result_t;

    // Controller states
    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;     // take a field and build the byte window
        logic step;     // result beat taken, advance to next byte
        logic cfg_wr;   // capacity write, clears the stream
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic last;     // current byte is the final one of the item
    } dp_status_t;

endpackage

[rtl/core/msbfp_ctrl.sv]
// ----------------------------------------------------------------------------
// msbfp_ctrl
// Controller: takes a field, walks its result beats one per unstalled cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module msbfp_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  field_valid,
    output logic                  field_stall,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    output logic                  result_valid,
    input  logic                  result_stall,
    output msbfp_pkg::dp_cmd_t    cmd,
    input  msbfp_pkg::dp_status_t status
);
    import msbfp_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (field_valid && !cfg_valid)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!result_stall && status.last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs; a config write wins over a field in the same cycle
    always_comb
    begin
        field_stall  = 1'b1;
        cfg_ready    = 1'b0;
        result_valid = 1'b0;
        cmd          = '0;
        case (state_reg)
            ST_IDLE:
            begin
                field_stall = cfg_valid;
                cfg_ready   = 1'b1;
                cmd.cfg_wr  = cfg_valid;
                cmd.load    = field_valid && !cfg_valid;
            end
            ST_EMIT:
            begin
                result_valid = 1'b1;
                cmd.step     = !result_stall;
            end
            default:
            begin
                field_stall = 1'b1;
            end
        endcase
    end

endmodule

[rtl/core/msbfp_dp.sv]
// ----------------------------------------------------------------------------
// msbfp_dp
// Datapath: stream state, capacity check, byte window and output beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module msbfp_dp
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  msbfp_pkg::dp_cmd_t            cmd,
    output msbfp_pkg::dp_status_t         status,
    input  msbfp_pkg::field_t             field,
    input  logic [msbfp_pkg::CAP_W-1:0]   cfg_data,
    output msbfp_pkg::result_t            result
);
    import msbfp_pkg::*;

    // Stream state
    logic [CAP_W-1:0] capacity_reg;
    logic [POS_W-1:0] bit_pos_reg;
    logic [POS_W-1:0] bit_pos_next;
    logic [7:0]       partial_reg;
    logic [7:0]       partial_next;

    // Beat registers
    logic [WIN_W-1:0] win_reg;
    logic [WIN_W-1:0] win_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic [CNT_W-1:0] remain_reg;
    logic [CNT_W-1:0] remain_next;
    logic             acc_reg;
    logic             acc_next;
    logic [CAP_W-1:0] len_reg;
    logic [CAP_W-1:0] len_next;

    // Load-time terms
    logic [CAP_W-1:0] cap_sat;
    logic [POS_W-1:0] cap_bits;
    logic [POS_W-1:0] pos_sum;
    logic             reject;
    logic [6:0]       total;
    logic [6:0]       total_rnd;
    logic [CNT_W-1:0] nb;
    logic [5:0]       shamt;
    logic [31:0]      val_masked;
    logic [WIN_W-1:0] window;
    logic [7:0]       tail_byte;
    logic [POS_W:0]   len_sum;

    // Capacity check and window build
    always_comb
    begin
        cap_sat    = (capacity_reg > CAP_MAX) ? CAP_MAX : capacity_reg;
        cap_bits   = {cap_sat, 3'b000};
        pos_sum    = bit_pos_reg + POS_W'(field.field_width);
        reject     = (field.field_width == 6'd0)
                     || (field.field_width > 6'(MAX_FIELD_BITS))
                     || (pos_sum > cap_bits);
        total      = 7'(bit_pos_reg[2:0]) + 7'(field.field_width);
        total_rnd  = total + 7'd7;
        nb         = total_rnd[5:3];
        shamt      = 6'(7'(WIN_W) - total);
        val_masked = field.field_value & ~(32'hFFFF_FFFF << field.field_width);
        window     = {partial_reg, 32'h0} | (WIN_W'(val_masked) << shamt);
        // byte that holds the new bit position
        case (total[5:3])
            3'd0:    tail_byte = window[39:32];
            3'd1:    tail_byte = window[31:24];
            3'd2:    tail_byte = window[23:16];
            3'd3:    tail_byte = window[15:8];
            3'd4:    tail_byte = window[7:0];
            default: tail_byte = 8'h00;
        endcase
    end

    // Next values
    always_comb
    begin
        bit_pos_next = bit_pos_reg;
        partial_next = partial_reg;
        win_next     = win_reg;
        idx_next     = idx_reg;
        remain_next  = remain_reg;
        acc_next     = acc_reg;
        len_next     = len_reg;
        len_sum      = {1'b0, bit_pos_reg} + (POS_W+1)'(7);
        if (cmd.cfg_wr)
        begin
            bit_pos_next = '0;
            partial_next = '0;
        end
        else if (cmd.load)
        begin
            if (reject)
            begin
                win_next    = '0;
                idx_next    = '0;
                remain_next = '0;
                acc_next    = 1'b0;
            end
            else
            begin
                bit_pos_next = pos_sum;
                partial_next = (total[2:0] != 3'd0) ? tail_byte : 8'h00;
                win_next     = window;
                idx_next     = bit_pos_reg[IDX_W+2:3];
                remain_next  = nb - CNT_W'(1);
                acc_next     = 1'b1;
                len_sum      = {1'b0, pos_sum} + (POS_W+1)'(7);
            end
            len_next = len_sum[CAP_W+2:3];
        end
        else if (cmd.step)
        begin
            win_next    = win_reg << 8;
            idx_next    = idx_reg + IDX_W'(1);
            remain_next = remain_reg - CNT_W'(1);
        end
    end

    // Stream state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
            bit_pos_reg  <= '0;
            partial_reg  <= '0;
        end
        else
        begin
            if (cmd.cfg_wr)
            begin
                capacity_reg <= cfg_data;
            end
            bit_pos_reg <= bit_pos_next;
            partial_reg <= partial_next;
        end
    end

    // Beat registers, no reset
    always_ff @(posedge clk)
    begin
        win_reg    <= win_next;
        idx_reg    <= idx_next;
        remain_reg <= remain_next;
        acc_reg    <= acc_next;
        len_reg    <= len_next;
    end

    // Output beat
    always_comb
    begin
        status.last         = (remain_reg == '0);
        result.write_valid  = acc_reg;
        result.byte_index   = idx_reg;
        result.byte_value   = win_reg[WIN_W-1 -: 8];
        result.accepted     = acc_reg;
        result.stream_bytes = len_reg;
        result.last         = status.last;
    end

endmodule

[rtl/core/msb_first_bit_field_packer.sv]
// ----------------------------------------------------------------------------
// msb_first_bit_field_packer
// Appends bit fields MSB first to a byte stream, one write per accepted beat.
// ----------------------------------------------------------------------------
//  channel  | signals                              | direction
//  ---------+--------------------------------------+----------
//  field    | field_valid, field_stall, field      | in
//  result   | result_valid, result_stall, result   | out
//  config   | cfg_valid, cfg_ready, cfg_data       | in
//
// A field is taken, then its result beats leave one per cycle unless
// result_stall holds them: one beat per byte touched (1 to 5), or one beat
// for a rejected field, stepped out of the single output register.
// Reset: capacity 256, stream empty. No field is taken while beats remain;
// result_stall holds the current beat in place.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module msb_first_bit_field_packer
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        field_valid,
    output logic                        field_stall,
    input  msbfp_pkg::field_t           field,
    output logic                        result_valid,
    input  logic                        result_stall,
    output msbfp_pkg::result_t          result,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [msbfp_pkg::CAP_W-1:0] cfg_data
);
    import msbfp_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    msbfp_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .field_valid  (field_valid),
        .field_stall  (field_stall),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cmd          (cmd),
        .status       (status)
    );

    msbfp_dp u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .field    (field),
        .cfg_data (cfg_data),
        .result   (result)
    );

endmodule

[rtl/core/msbfp_checker.sv]
// ----------------------------------------------------------------------------
// msbfp_checker
// Port-level checks on the bit-field packer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "msb_first_bit_field_packer_macros.svh"

module msbfp_checker
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        field_valid,
    input logic                        field_stall,
    input logic                        result_valid,
    input logic                        result_stall,
    input msbfp_pkg::result_t          result,
    input logic                        cfg_ready
);
    import msbfp_pkg::*;

    logic field_beat;
    logic result_beat;

    assign field_beat  = field_valid && !field_stall;
    assign result_beat = result_valid && !result_stall;

    // A taken field always produces a beat next cycle
    `MSBFP_ASSERT_NXT(a_field_gives_result, field_beat, result_valid, "no result after field")

    // No field and no config write is taken while beats are pending
    `MSBFP_ASSERT_IMP(a_no_overlap, result_valid, field_stall && !cfg_ready,
        "input taken during output")

    // A rejected field is a single beat with no write
    `MSBFP_ASSERT_IMP(a_reject_single, result_valid && !result.accepted,
        result.last && !result.write_valid, "bad rejected beat")

    // Bytes of one field go to consecutive positions
    `MSBFP_ASSERT_NXT(a_index_steps, result_beat && !result.last,
        result_valid && (result.byte_index == $past(result.byte_index) + 16'd1),
        "byte index not consecutive")

    // The final beat ends the item
    `MSBFP_ASSERT_NXT(a_last_ends, result_beat && result.last, !result_valid,
        "beat after last")

endmodule

bind msb_first_bit_field_packer msbfp_checker u_checker (.*);
